@@ src/pts_pkg.sv @@
package pts_pkg;

    localparam int NUM_TASKS     = 8;
    localparam int PRIORITY_BITS = 4;
    localparam int IDX_W         = 3;
    localparam int SP_W          = 32;
    localparam int DLY_W         = 32;
    localparam int STAT_W        = 3;
    localparam int FUNC_W        = 3;
    localparam int CNT_W         = $clog2(NUM_TASKS + 1);
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 72;

    localparam logic [STAT_W-1:0] STAT_READY   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RUNNING = 3'd2;
    localparam logic [STAT_W-1:0] STAT_WAITING = 3'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 3'd0,
        FN_DELAY  = 3'd1,
        FN_STATUS = 3'd2,
        FN_SWITCH = 3'd3,
        FN_CREATE = 3'd4
    } func_t;

    typedef enum logic {
        S_ACCEPT,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic                     tick;
        logic                     st_en;
        logic [IDX_W-1:0]         st_idx;
        logic [STAT_W-1:0]        st_val;
        logic                     dly_en;
        logic [DLY_W-1:0]         dly_val;
        logic                     crt_en;
        logic [SP_W-1:0]          sp_val;
        logic [PRIORITY_BITS-1:0] pri_val;
        logic                     save_en;
        logic [IDX_W-1:0]         save_idx;
        logic                     run_en;
        logic [IDX_W-1:0]         run_idx;
    } cell_cmd_t;

    typedef struct packed {
        logic                     found;
        logic [PRIORITY_BITS-1:0] pri;
        logic [IDX_W-1:0]         idx;
        logic [SP_W-1:0]          sp;
    } best_t;

endpackage

@@ src/pts_cell.sv @@
module pts_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pts_pkg::IDX_W-1:0] cell_idx,
    input  pts_pkg::cell_cmd_t        cmd,
    input  pts_pkg::best_t            best_in,
    output pts_pkg::best_t            best_out
);

    logic [pts_pkg::STAT_W-1:0]        status_reg, status_next;
    logic [pts_pkg::DLY_W-1:0]         delay_reg, delay_next;
    logic [pts_pkg::SP_W-1:0]          sp_reg, sp_next;
    logic [pts_pkg::PRIORITY_BITS-1:0] pri_reg, pri_next;
    pts_pkg::best_t                    best_reg, best_next;
    logic                              take;

    always_comb begin
        status_next = status_reg;
        delay_next  = delay_reg;
        sp_next     = sp_reg;
        pri_next    = pri_reg;
        if (cmd.tick && status_reg == pts_pkg::STAT_WAITING && delay_reg != '0) begin
            delay_next = delay_reg - 1'b1;
            if (delay_reg == pts_pkg::DLY_W'(1)) begin
                status_next = pts_pkg::STAT_READY;
            end
        end
        if (cmd.st_en && cmd.st_idx == cell_idx) begin
            status_next = cmd.st_val;
            if (cmd.dly_en) begin
                delay_next = cmd.dly_val;
            end
            if (cmd.crt_en) begin
                sp_next  = cmd.sp_val;
                pri_next = cmd.pri_val;
            end
        end
        if (cmd.save_en && cmd.save_idx == cell_idx) begin
            sp_next = cmd.sp_val;
            if (status_reg == pts_pkg::STAT_RUNNING) begin
                status_next = pts_pkg::STAT_READY;
            end
        end
        if (cmd.run_en && cmd.run_idx == cell_idx) begin
            status_next = pts_pkg::STAT_RUNNING;
        end
    end

    // Later cells win ties, so the higher index is kept on equal priority.
    always_comb begin
        take = (status_reg == pts_pkg::STAT_READY) &&
               (!best_in.found || pri_reg >= best_in.pri);
        best_next = best_in;
        if (take) begin
            best_next.found = 1'b1;
            best_next.pri   = pri_reg;
            best_next.idx   = cell_idx;
            best_next.sp    = sp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '0;
            delay_reg  <= '0;
            best_reg   <= '0;
        end else begin
            status_reg <= status_next;
            delay_reg  <= delay_next;
            best_reg   <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        sp_reg  <= sp_next;
        pri_reg <= pri_next;
    end

    assign best_out = best_reg;

endmodule

@@ src/priority_task_scheduler_core.sv @@
// Channel   Direction  Words carried
// s_axis    in         one scheduler request per word (function code in tuser)
// m_axis    out        one result word per request
// cfg       in         idle context start stack pointer
//
// Any word other than a switch has its result registered as it is taken,
// so its result word is valid in the cycle after.
// A switch word waits in the scan state while the selection runs through the
// chain of task cells, one cell per cycle, before the decision is made.
// Reset is synchronous and active low; no clearing pass is needed.
// A new word is taken only while the result register is empty or being read.
module priority_task_scheduler_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_index, new_status, delay_ticks, stack_pointer, priority_req
    input  logic [pts_pkg::IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [pts_pkg::FUNC_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // next_sp, running_is_idle, running_index, tick_count, switch_pending
    output logic [pts_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pts_pkg::SP_W-1:0]       cfg_data
);

    localparam int N = pts_pkg::NUM_TASKS;

    pts_pkg::state_t                   state_reg, state_next;
    logic [pts_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              idle_running_reg, idle_running_next;
    logic [pts_pkg::IDX_W-1:0]         running_slot_reg, running_slot_next;
    logic                              first_switch_reg, first_switch_next;
    logic [pts_pkg::SP_W-1:0]          idle_saved_sp_reg, idle_saved_sp_next;
    logic                              idle_sp_valid_reg, idle_sp_valid_next;
    logic [pts_pkg::SP_W-1:0]          ticks_reg, ticks_next;
    logic [pts_pkg::SP_W-1:0]          idle_start_sp_reg;
    logic [pts_pkg::SP_W-1:0]          item_sp_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [pts_pkg::SP_W-1:0]          out_sp_reg;
    logic                              out_idle_reg;
    logic [pts_pkg::IDX_W-1:0]         out_idx_reg;
    logic [pts_pkg::SP_W-1:0]          out_ticks_reg;
    logic                              out_pend_reg;

    pts_pkg::func_t                    in_func;
    logic [pts_pkg::IDX_W-1:0]         in_idx;
    logic [pts_pkg::STAT_W-1:0]        in_status;
    logic [pts_pkg::DLY_W-1:0]         in_dly;
    logic [pts_pkg::SP_W-1:0]          in_sp;
    logic [pts_pkg::PRIORITY_BITS-1:0] in_pri;
    logic                              idx_ok;

    logic                              accept;
    logic                              out_free;
    logic                              decide;
    logic                              load_out;
    logic                              same;
    logic                              pend;
    logic [pts_pkg::SP_W-1:0]          res_sp;
    pts_pkg::cell_cmd_t                cmd;
    pts_pkg::best_t                    sel;
    pts_pkg::best_t                    chain [N+1];

    assign in_func   = pts_pkg::func_t'(s_tuser);
    assign in_idx    = s_tdata[2:0];
    assign in_status = s_tdata[5:3];
    assign in_dly    = s_tdata[37:6];
    assign in_sp     = s_tdata[69:38];
    assign in_pri    = s_tdata[73:70];
    assign idx_ok    = {1'b0, in_idx} < (pts_pkg::IDX_W + 1)'(N);

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign chain[0] = '0;
    assign sel      = chain[N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        pts_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (pts_pkg::IDX_W'(g)),
            .cmd      (cmd),
            .best_in  (chain[g]),
            .best_out (chain[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::S_ACCEPT: begin
                if (accept && in_func == pts_pkg::FN_SWITCH) begin
                    state_next = pts_pkg::S_SCAN;
                end
            end
            pts_pkg::S_SCAN: begin
                if (decide) begin
                    state_next = pts_pkg::S_ACCEPT;
                end
            end
            default: state_next = pts_pkg::S_ACCEPT;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        decide   = 1'b0;
        case (state_reg)
            pts_pkg::S_ACCEPT: s_tready = out_free;
            pts_pkg::S_SCAN:   decide = (cnt_reg == pts_pkg::CNT_W'(N)) && out_free;
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = '0;
        end else if (state_reg == pts_pkg::S_SCAN && cnt_reg != pts_pkg::CNT_W'(N)) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        cmd                = '0;
        cmd.sp_val         = decide ? item_sp_reg : in_sp;
        cmd.pri_val        = in_pri;
        idle_running_next  = idle_running_reg;
        running_slot_next  = running_slot_reg;
        first_switch_next  = first_switch_reg;
        idle_saved_sp_next = idle_saved_sp_reg;
        idle_sp_valid_next = idle_sp_valid_reg;
        ticks_next         = ticks_reg;
        res_sp             = in_sp;
        pend               = 1'b0;
        same               = 1'b0;
        load_out           = accept && in_func != pts_pkg::FN_SWITCH;

        if (accept) begin
            case (in_func)
                pts_pkg::FN_TICK: begin
                    cmd.tick   = 1'b1;
                    ticks_next = ticks_reg + 1'b1;
                    pend       = 1'b1;
                end
                pts_pkg::FN_DELAY: begin
                    if (!idle_running_reg) begin
                        cmd.st_en   = 1'b1;
                        cmd.st_idx  = running_slot_reg;
                        cmd.st_val  = pts_pkg::STAT_WAITING;
                        cmd.dly_en  = 1'b1;
                        cmd.dly_val = in_dly;
                        pend        = 1'b1;
                    end
                end
                pts_pkg::FN_STATUS: begin
                    if (idx_ok) begin
                        cmd.st_en  = 1'b1;
                        cmd.st_idx = in_idx;
                        cmd.st_val = in_status;
                        pend       = 1'b1;
                    end
                end
                pts_pkg::FN_CREATE: begin
                    if (idx_ok) begin
                        cmd.st_en   = 1'b1;
                        cmd.st_idx  = in_idx;
                        cmd.st_val  = pts_pkg::STAT_READY;
                        cmd.dly_en  = 1'b1;
                        cmd.dly_val = '0;
                        cmd.crt_en  = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (decide) begin
            res_sp = item_sp_reg;
            same   = (idle_running_reg && !sel.found) ||
                     (!idle_running_reg && sel.found && sel.idx == running_slot_reg);
            if (!same) begin
                if (idle_running_reg) begin
                    if (!first_switch_reg) begin
                        idle_saved_sp_next = item_sp_reg;
                        idle_sp_valid_next = 1'b1;
                    end
                    first_switch_next = 1'b0;
                end else begin
                    cmd.save_en  = 1'b1;
                    cmd.save_idx = running_slot_reg;
                end
                if (!sel.found) begin
                    idle_running_next = 1'b1;
                    running_slot_next = '0;
                    res_sp = idle_sp_valid_reg ? idle_saved_sp_reg : idle_start_sp_reg;
                end else begin
                    idle_running_next = 1'b0;
                    running_slot_next = sel.idx;
                    cmd.run_en        = 1'b1;
                    cmd.run_idx       = sel.idx;
                    res_sp            = sel.sp;
                end
            end
            load_out = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= pts_pkg::S_ACCEPT;
            cnt_reg           <= '0;
            idle_running_reg  <= 1'b1;
            running_slot_reg  <= '0;
            first_switch_reg  <= 1'b1;
            idle_saved_sp_reg <= '0;
            idle_sp_valid_reg <= 1'b0;
            ticks_reg         <= '0;
            idle_start_sp_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            idle_running_reg  <= idle_running_next;
            running_slot_reg  <= running_slot_next;
            first_switch_reg  <= first_switch_next;
            idle_saved_sp_reg <= idle_saved_sp_next;
            idle_sp_valid_reg <= idle_sp_valid_next;
            ticks_reg         <= ticks_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                idle_start_sp_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_sp_reg <= in_sp;
        end
        if (load_out) begin
            out_sp_reg    <= res_sp;
            out_idle_reg  <= idle_running_next;
            out_idx_reg   <= idle_running_next ? '0 : running_slot_next;
            out_ticks_reg <= ticks_next;
            out_pend_reg  <= pend;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pend_reg, out_ticks_reg, out_idx_reg, out_idle_reg,
                       out_sp_reg};

    a_simple_word_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_func != pts_pkg::FN_SWITCH |=> m_tvalid)
        else $error("result of a single-cycle word did not appear");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pts_pkg::S_SCAN |-> !s_tready)
        else $error("word taken while a switch is being resolved");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pts_pkg::CNT_W'(N))
        else $error("scan counter ran past the chain length");

    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_running_reg |-> running_slot_reg == '0)
        else $error("running slot not cleared while idle runs");

    a_switch_result: assert property (@(posedge aclk) disable iff (!aresetn)
        decide |=> m_tvalid && out_pend_reg == 1'b0)
        else $error("switch result missing or marked pending");

endmodule

@@ tb/priority_task_scheduler_core_test.sv @@
`timescale 1ns / 1ps

module priority_task_scheduler_core_test;

    import pts_pkg::*;

    localparam logic [STAT_W-1:0] STAT_FREE      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SUSPENDED = 3'd4;
    localparam logic [STAT_W-1:0] STAT_SPARE     = 3'd5;
    localparam logic [STAT_W-1:0] STAT_TOP       = 3'd7;
    localparam logic [FUNC_W-1:0] FN_SPARE       = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RESERVED    = 3'd7;
    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE       = 2 * (NUM_TASKS + 2);
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         idx;
        logic [STAT_W-1:0]        nstat;
        logic [DLY_W-1:0]         dly;
        logic [SP_W-1:0]          sp;
        logic [PRIORITY_BITS-1:0] pri;
    } sched_req_t;

    typedef struct packed {
        logic [SP_W-1:0]  next_sp;
        logic             idle;
        logic [IDX_W-1:0] run_idx;
        logic [31:0]      ticks;
        logic             pend;
    } sched_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SP_W-1:0]       cfg_data  = '0;

    sched_req_t    pending_reqs[$];
    sched_result_t expected_results[$];
    sched_req_t    drv_next;
    sched_result_t seen;
    sched_result_t want;

    bit            quiet = 1'b0;
    bit            failed = 1'b0;
    bit            made[NUM_TASKS];
    int            results_seen = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int            cycles = 0;

    // Scheduler state as predicted by the testbench.
    logic [STAT_W-1:0]        slot_state[NUM_TASKS] = '{default: STAT_FREE};
    logic [DLY_W-1:0]         slot_wait[NUM_TASKS] = '{default: '0};
    logic [SP_W-1:0]          slot_sp[NUM_TASKS] = '{default: '0};
    logic [PRIORITY_BITS-1:0] slot_pri[NUM_TASKS] = '{default: '0};
    logic                     idle_active = 1'b1;
    logic [IDX_W-1:0]         cur_slot = '0;
    logic                     first_pick = 1'b1;
    logic [SP_W-1:0]          idle_saved = '0;
    logic                     idle_saved_ok = 1'b0;
    logic [31:0]              tick_total = '0;
    logic [SP_W-1:0]          idle_start_copy = '0;

    priority_task_scheduler_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [IN_DATA_W-1:0] pack_request(sched_req_t r);
        return {6'b0, r.pri, r.sp, r.dly, r.nstat, r.idx};
    endfunction

    function automatic sched_result_t schedule_step(logic [FUNC_W-1:0] fn,
                                                    logic [IN_DATA_W-1:0] d);
        logic [IDX_W-1:0]         idx;
        logic [STAT_W-1:0]        nst;
        logic [DLY_W-1:0]         dly;
        logic [SP_W-1:0]          sp;
        logic [SP_W-1:0]          nxt;
        logic [PRIORITY_BITS-1:0] pri;
        logic [PRIORITY_BITS-1:0] best;
        logic                     pend;
        int                       sel;
        sched_result_t            r;
        idx  = d[2:0];
        nst  = d[5:3];
        dly  = d[37:6];
        sp   = d[69:38];
        pri  = d[73:70];
        nxt  = sp;
        pend = 1'b0;
        case (fn)
            FN_TICK: begin
                tick_total = tick_total + 1;
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (slot_state[i] == STAT_WAITING && slot_wait[i] != 0) begin
                        slot_wait[i] = slot_wait[i] - 1;
                        if (slot_wait[i] == 0) begin
                            slot_state[i] = STAT_READY;
                        end
                    end
                end
                pend = 1'b1;
            end
            FN_DELAY: begin
                if (!idle_active) begin
                    slot_wait[cur_slot]  = dly;
                    slot_state[cur_slot] = STAT_WAITING;
                    pend = 1'b1;
                end
            end
            FN_STATUS: begin
                slot_state[idx] = nst;
                pend = 1'b1;
            end
            FN_SWITCH: begin
                sel  = -1;
                best = '0;
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (slot_state[i] == STAT_READY && slot_pri[i] >= best) begin
                        sel  = i;
                        best = slot_pri[i];
                    end
                end
                if (idle_active ? (sel >= 0) : (sel != int'(cur_slot))) begin
                    if (idle_active) begin
                        if (!first_pick) begin
                            idle_saved    = sp;
                            idle_saved_ok = 1'b1;
                        end
                        first_pick = 1'b0;
                    end else begin
                        slot_sp[cur_slot] = sp;
                        if (slot_state[cur_slot] == STAT_RUNNING) begin
                            slot_state[cur_slot] = STAT_READY;
                        end
                    end
                    if (sel < 0) begin
                        idle_active = 1'b1;
                        cur_slot    = '0;
                        nxt = idle_saved_ok ? idle_saved : idle_start_copy;
                    end else begin
                        idle_active     = 1'b0;
                        cur_slot        = sel[IDX_W-1:0];
                        slot_state[sel] = STAT_RUNNING;
                        nxt = slot_sp[sel];
                    end
                end
            end
            FN_CREATE: begin
                slot_sp[idx]    = sp;
                slot_pri[idx]   = pri;
                slot_wait[idx]  = '0;
                slot_state[idx] = STAT_READY;
            end
            default: begin
            end
        endcase
        r.next_sp = nxt;
        r.idle    = idle_active;
        r.run_idx = idle_active ? '0 : cur_slot;
        r.ticks   = tick_total;
        r.pend    = pend;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(schedule_step(s_tuser, s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 38)) begin
                    drv_next = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_request(drv_next);
                    s_tuser  <= drv_next.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.next_sp = m_tdata[31:0];
                seen.idle    = m_tdata[32];
                seen.run_idx = m_tdata[35:33];
                seen.ticks   = m_tdata[67:36];
                seen.pend    = m_tdata[68];
                results_seen = results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.next_sp !== want.next_sp) begin
                        $error("next_sp: expected %h, got %h", want.next_sp, seen.next_sp);
                        failed = 1'b1;
                    end
                    if (seen.idle !== want.idle) begin
                        $error("running_is_idle: expected %0d, got %0d", want.idle, seen.idle);
                        failed = 1'b1;
                    end
                    if (seen.run_idx !== want.run_idx) begin
                        $error("running_index: expected %0d, got %0d",
                               want.run_idx, seen.run_idx);
                        failed = 1'b1;
                    end
                    if (seen.ticks !== want.ticks) begin
                        $error("tick_count: expected %h, got %h", want.ticks, seen.ticks);
                        failed = 1'b1;
                    end
                    if (seen.pend !== want.pend) begin
                        $error("switch_pending: expected %0d, got %0d", want.pend, seen.pend);
                        failed = 1'b1;
                    end
                end
            end
            // The receiver stops once for a long stretch so that the core backs up.
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || $urandom_range(99) >= 38;
            end
        end
    end

    always @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            idle_start_copy <= cfg_data;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_idle_sp(logic [SP_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic add_req(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                           logic [STAT_W-1:0] nst, logic [DLY_W-1:0] dly,
                           logic [SP_W-1:0] sp, logic [PRIORITY_BITS-1:0] pri);
        sched_req_t r;
        r = '{func: fn, idx: idx, nstat: nst, dly: dly, sp: sp, pri: pri};
        if (fn == FN_CREATE) begin
            made[idx] = 1'b1;
        end
        pending_reqs.push_back(r);
    endtask

    task automatic add_random_reqs(int count);
        sched_req_t r;
        int         pick;
        for (int n = 0; n < count; n++) begin
            r.idx   = $urandom_range(NUM_TASKS - 1);
            r.nstat = $urandom_range(STAT_TOP);
            r.dly   = $urandom;
            r.sp    = $urandom;
            r.pri   = $urandom_range((1 << PRIORITY_BITS) - 1);
            pick    = $urandom_range(99);
            if (pick < 12) begin
                r.func = FN_CREATE;
            end else if (pick < 37) begin
                r.func = FN_SWITCH;
            end else if (pick < 60) begin
                r.func = FN_TICK;
            end else if (pick < 75) begin
                r.func = FN_DELAY;
                if ($urandom_range(9) < 8) begin
                    r.dly = $urandom_range(6);
                end
            end else if (pick < 97) begin
                r.func = FN_STATUS;
            end else begin
                r.func = $urandom_range(FN_SPARE, FN_RESERVED);
            end
            // A slot that was never created must not be made ready.
            if (r.func == FN_STATUS && !made[r.idx] && r.nstat == STAT_READY) begin
                r.nstat = STAT_SUSPENDED;
            end
            add_req(r.func, r.idx, r.nstat, r.dly, r.sp, r.pri);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_idle_sp(32'h0000_0000);
        add_req(FN_DELAY,  3'd7, STAT_TOP,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h0,         4'h0);
        add_req(FN_CREATE, 3'd0, STAT_FREE,      32'h0,         32'h0000_1000, 4'h0);
        add_req(FN_CREATE, 3'd7, STAT_FREE,      32'h0,         32'hFFFF_FFFF, 4'hF);
        add_req(FN_CREATE, 3'd3, STAT_FREE,      32'h0,         32'h1234_5678, 4'hF);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'hAAAA_0000, 4'h0);
        add_req(FN_STATUS, 3'd7, STAT_READY,     32'h0,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h0000_5555, 4'h0);
        add_req(FN_DELAY,  3'd0, STAT_FREE,      32'd2,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h7000_0007, 4'h0);
        add_req(FN_DELAY,  3'd0, STAT_FREE,      32'd0,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h3000_0003, 4'h0);
        add_req(FN_STATUS, 3'd0, STAT_SUSPENDED, 32'h0,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h0C00_0000, 4'h0);
        add_req(FN_TICK,   3'd0, STAT_FREE,      32'h0,         32'h0,         4'h0);
        add_req(FN_TICK,   3'd7, STAT_TOP,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'hDEAD_0001, 4'h0);
        add_req(FN_STATUS, 3'd3, STAT_SPARE,     32'h0,         32'h0,         4'h0);
        add_req(FN_STATUS, 3'd3, STAT_READY,     32'h0,         32'h0,         4'h0);
        add_req(FN_SPARE,  3'd7, STAT_TOP,       32'hFFFF_FFFF, 32'h8765_4321, 4'hF);
        add_req(FN_RESERVED, 3'd0, STAT_FREE,    32'h0,         32'h0000_0001, 4'h0);
        add_req(FN_STATUS, 3'd7, STAT_FREE,      32'h0,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h0707_0707, 4'h0);
        add_req(FN_STATUS, 3'd3, STAT_WAITING,   32'h0,         32'h0,         4'h0);
        add_req(FN_SWITCH, 3'd0, STAT_FREE,      32'h0,         32'h0303_0303, 4'h0);
        wait_drained();

        write_idle_sp(32'hFFFF_FFFF);
        add_random_reqs(210);
        wait_drained();

        // The second random phase runs with neither side idling.
        quiet = 1'b1;
        write_idle_sp($urandom);
        add_random_reqs(210);
        wait_drained();
        quiet = 1'b0;

        write_idle_sp($urandom);
        add_random_reqs(210);
        wait_drained();

        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ priority_task_scheduler_core.f @@
src/pts_pkg.sv
src/pts_cell.sv
src/priority_task_scheduler_core.sv
tb/priority_task_scheduler_core_test.sv
